### hw/rtl/ray_sphere_intersect_macros.svh
// assertion macros for the checker file of the ray/sphere block
`ifndef RAY_SPHERE_INTERSECT_MACROS_SVH
`define RAY_SPHERE_INTERSECT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define RSI_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is active
`define RSI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/rsi_pkg.sv
// shared types and constants of the ray/sphere intersection pipeline
`default_nettype none

package rsi_pkg;

    // fraction bits of all fixed-point coordinates and of the distance
    localparam int FRAC_BITS = 16;

    // exact widths of the intermediate terms
    localparam int W_A   = 64;   // V.V, unsigned
    localparam int W_B   = 66;   // V.D, signed
    localparam int W_C   = 67;   // D.D - R*R, signed
    localparam int W_BM  = 65;   // |B|
    localparam int W_CM  = 66;   // |C|
    localparam int W_SQ  = 130;  // B*B and A*|C|
    localparam int W_E   = 132;  // discriminant, signed
    localparam int SQ_STEPS = 66; // result bits of the square root
    localparam int W_S   = SQ_STEPS;
    localparam int W_N   = 67;   // numerator -B -/+ s, unsigned
    localparam int DIV_STEPS = 32; // quotient bits
    localparam int W_REM = W_A + DIV_STEPS;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic        [30:0] radius;
    } t_in;

    typedef struct packed {
        logic        hit;
        logic [31:0] hit_distance;
    } t_out;

    // quadratic coefficients after the dot products
    typedef struct packed {
        logic             nohit;
        logic [W_A-1:0]   a;
        logic [W_B-1:0]   b;
        logic [W_C-1:0]   c;
    } t_abc;

    // discriminant plus what root selection needs
    typedef struct packed {
        logic             nohit;
        logic             near;
        logic [W_A-1:0]   a;
        logic [W_B-1:0]   b;
        logic [W_E-1:0]   e;
    } t_eq;

    // square root plus what the divider needs
    typedef struct packed {
        logic             nohit;
        logic             near;
        logic [W_A-1:0]   a;
        logic [W_B-1:0]   b;
        logic [W_S-1:0]   s;
    } t_sq;

endpackage

`default_nettype wire

### hw/rtl/rsi_setup.sv
// slab rejection and the three dot products a, b, c
`default_nettype none

module rsi_setup import rsi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_item,
    output logic o_valid,
    input  logic i_stall,
    output t_abc o_abc
);

    logic [31:0] w_org [3];
    logic [31:0] w_dir [3];
    logic [31:0] w_ctr [3];
    logic signed [32:0] w_rad;
    logic signed [32:0] w_oe [3];
    logic signed [32:0] w_up [3];
    logic signed [32:0] w_dn [3];

    assign w_org[0] = i_item.origin_x;
    assign w_org[1] = i_item.origin_y;
    assign w_org[2] = i_item.origin_z;
    assign w_dir[0] = i_item.dir_x;
    assign w_dir[1] = i_item.dir_y;
    assign w_dir[2] = i_item.dir_z;
    assign w_ctr[0] = i_item.center_x;
    assign w_ctr[1] = i_item.center_y;
    assign w_ctr[2] = i_item.center_z;
    assign w_rad    = $signed({2'b00, i_item.radius});

    logic w_rdy1, w_rdy2, w_rdy3;
    logic r1_v, r2_v, r3_v;

    // stage 1: origin minus center, slab test
    logic        n1_rej;
    logic [32:0] n1_d [3];
    logic        r1_rej;
    logic [31:0] r1_dir [3];
    logic [32:0] r1_d [3];
    logic [30:0] r1_rad;

    always_comb begin
        n1_rej = 1'b0;
        for (int ax = 0; ax < 3; ax++) begin
            w_oe[ax] = $signed({w_org[ax][31], w_org[ax]});
            w_up[ax] = $signed({w_ctr[ax][31], w_ctr[ax]}) + w_rad;
            w_dn[ax] = $signed({w_ctr[ax][31], w_ctr[ax]}) - w_rad;
            n1_d[ax] = {w_org[ax][31], w_org[ax]} - {w_ctr[ax][31], w_ctr[ax]};
            if (($signed(w_dir[ax]) > 0 && w_oe[ax] > w_up[ax]) ||
                ($signed(w_dir[ax]) < 0 && w_oe[ax] < w_dn[ax])) begin
                n1_rej = 1'b1;
            end
        end
    end

    // stage 2: products per axis
    logic [63:0] n2_vv [3];
    logic [63:0] n2_vd [3];
    logic [63:0] n2_dd [3];
    logic [61:0] n2_rr;
    logic [63:0] r2_vv [3];
    logic [63:0] r2_vd [3];
    logic [63:0] r2_dd [3];
    logic [61:0] r2_rr;
    logic        r2_rej;

    always_comb begin
        for (int ax = 0; ax < 3; ax++) begin
            n2_vv[ax] = $signed({{32{r1_dir[ax][31]}}, r1_dir[ax]})
                      * $signed({{32{r1_dir[ax][31]}}, r1_dir[ax]});
            n2_vd[ax] = $signed({{32{r1_dir[ax][31]}}, r1_dir[ax]})
                      * $signed({{31{r1_d[ax][32]}}, r1_d[ax]});
            n2_dd[ax] = $signed({{31{r1_d[ax][32]}}, r1_d[ax]})
                      * $signed({{31{r1_d[ax][32]}}, r1_d[ax]});
        end
        n2_rr = {31'b0, r1_rad} * {31'b0, r1_rad};
    end

    // stage 3: sums
    t_abc n3_abc;
    t_abc r3_abc;

    always_comb begin
        n3_abc.nohit = r2_rej;
        n3_abc.a = r2_vv[0] + r2_vv[1] + r2_vv[2];
        n3_abc.b = {{2{r2_vd[0][63]}}, r2_vd[0]} + {{2{r2_vd[1][63]}}, r2_vd[1]}
                 + {{2{r2_vd[2][63]}}, r2_vd[2]};
        n3_abc.c = {3'b0, r2_dd[0]} + {3'b0, r2_dd[1]} + {3'b0, r2_dd[2]}
                 - {5'b0, r2_rr};
    end

    assign w_rdy3  = !r3_v || !i_stall;
    assign w_rdy2  = !r2_v || w_rdy3;
    assign w_rdy1  = !r1_v || w_rdy2;
    assign o_stall = !w_rdy1;
    assign o_valid = r3_v;
    assign o_abc   = r3_abc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (w_rdy1) r1_v <= i_valid;
            if (w_rdy2) r2_v <= r1_v;
            if (w_rdy3) r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r1_rej <= n1_rej;
            r1_dir <= w_dir;
            r1_d   <= n1_d;
            r1_rad <= i_item.radius;
        end
        if (w_rdy2) begin
            r2_vv  <= n2_vv;
            r2_vd  <= n2_vd;
            r2_dd  <= n2_dd;
            r2_rr  <= n2_rr;
            r2_rej <= r1_rej;
        end
        if (w_rdy3) begin
            r3_abc <= n3_abc;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/rsi_quad.sv
// discriminant b*b - a*c from split partial products, root choice flags
`default_nettype none

module rsi_quad import rsi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_abc i_abc,
    output logic o_valid,
    input  logic i_stall,
    output t_eq  o_eq
);

    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    logic r1_v, r2_v, r3_v, r4_v;

    // stage 1: signs, magnitudes, root selection
    logic            w_bneg, w_bzero, w_cneg, w_czero, w_near, w_far;
    logic [W_B-1:0]  w_bfull;
    logic [W_C-1:0]  w_cfull;
    logic            r1_nohit, r1_near, r1_cneg;
    logic [W_A-1:0]  r1_a;
    logic [W_B-1:0]  r1_b;
    logic [W_BM-1:0] r1_bm;
    logic [W_CM-1:0] r1_cm;

    always_comb begin
        w_bneg  = i_abc.b[W_B-1];
        w_bzero = (i_abc.b == '0);
        w_cneg  = i_abc.c[W_C-1];
        w_czero = (i_abc.c == '0);
        // nearer root usable: b <= 0 and c >= 0; farther: b <= 0 or c <= 0
        w_near  = (w_bneg || w_bzero) && !w_cneg;
        w_far   = w_bneg || w_bzero || w_cneg || w_czero;
        w_bfull = w_bneg ? ('0 - i_abc.b) : i_abc.b;
        w_cfull = w_cneg ? ('0 - i_abc.c) : i_abc.c;
    end

    // stage 2: partial products, 32- and 33-bit pieces
    logic [65:0] r2_bll;
    logic [64:0] r2_blh;
    logic [63:0] r2_bhh;
    logic [64:0] r2_all, r2_alh, r2_ahl, r2_ahh;
    logic        r2_nohit, r2_near, r2_cneg;
    logic [W_A-1:0] r2_a;
    logic [W_B-1:0] r2_b;

    // stage 3: b*b and a*|c|
    logic [W_SQ-1:0] r3_b2, r3_ac;
    logic            r3_nohit, r3_near, r3_cneg;
    logic [W_A-1:0]  r3_a;
    logic [W_B-1:0]  r3_b;

    // stage 4: discriminant
    t_eq  n4_eq;
    t_eq  r4_eq;

    always_comb begin
        n4_eq.near = r3_near;
        n4_eq.a    = r3_a;
        n4_eq.b    = r3_b;
        n4_eq.e    = r3_cneg ? ({2'b00, r3_b2} + {2'b00, r3_ac})
                             : ({2'b00, r3_b2} - {2'b00, r3_ac});
        n4_eq.nohit = r3_nohit || n4_eq.e[W_E-1];
    end

    assign w_rdy4  = !r4_v || !i_stall;
    assign w_rdy3  = !r3_v || w_rdy4;
    assign w_rdy2  = !r2_v || w_rdy3;
    assign w_rdy1  = !r1_v || w_rdy2;
    assign o_stall = !w_rdy1;
    assign o_valid = r4_v;
    assign o_eq    = r4_eq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (w_rdy1) r1_v <= i_valid;
            if (w_rdy2) r2_v <= r1_v;
            if (w_rdy3) r3_v <= r2_v;
            if (w_rdy4) r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r1_nohit <= i_abc.nohit || (i_abc.a == '0) || !w_far;
            r1_near  <= w_near;
            r1_cneg  <= w_cneg;
            r1_a     <= i_abc.a;
            r1_b     <= i_abc.b;
            r1_bm    <= w_bfull[W_BM-1:0];
            r1_cm    <= w_cfull[W_CM-1:0];
        end
        if (w_rdy2) begin
            r2_bll   <= {33'b0, r1_bm[32:0]} * {33'b0, r1_bm[32:0]};
            r2_blh   <= {32'b0, r1_bm[32:0]} * {33'b0, r1_bm[64:33]};
            r2_bhh   <= {32'b0, r1_bm[64:33]} * {32'b0, r1_bm[64:33]};
            r2_all   <= {33'b0, r1_a[31:0]} * {32'b0, r1_cm[32:0]};
            r2_alh   <= {33'b0, r1_a[31:0]} * {32'b0, r1_cm[65:33]};
            r2_ahl   <= {33'b0, r1_a[63:32]} * {32'b0, r1_cm[32:0]};
            r2_ahh   <= {33'b0, r1_a[63:32]} * {32'b0, r1_cm[65:33]};
            r2_nohit <= r1_nohit;
            r2_near  <= r1_near;
            r2_cneg  <= r1_cneg;
            r2_a     <= r1_a;
            r2_b     <= r1_b;
        end
        if (w_rdy3) begin
            // cross term counted twice: shift by 34 rather than 33
            r3_b2    <= {r2_bhh, 66'b0} + {31'b0, r2_blh, 34'b0} + {64'b0, r2_bll};
            r3_ac    <= {r2_ahh, 65'b0} + {32'b0, r2_alh, 33'b0}
                      + {33'b0, r2_ahl, 32'b0} + {65'b0, r2_all};
            r3_nohit <= r2_nohit;
            r3_near  <= r2_near;
            r3_cneg  <= r2_cneg;
            r3_a     <= r2_a;
            r3_b     <= r2_b;
        end
        if (w_rdy4) begin
            r4_eq <= n4_eq;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/rsi_sqrt.sv
// truncated square root of the discriminant, one result bit per stage
`default_nettype none

module rsi_sqrt import rsi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_eq  i_eq,
    output logic o_valid,
    input  logic i_stall,
    output t_sq  o_sq
);

    typedef struct packed {
        logic           nohit;
        logic           near;
        logic [W_A-1:0] a;
        logic [W_B-1:0] b;
    } t_side;

    logic [SQ_STEPS:0] w_rdy;
    logic              r_v   [SQ_STEPS];
    logic [W_E-1:0]    r_num [SQ_STEPS];
    logic [W_E-1:0]    r_res [SQ_STEPS];
    t_side             r_sd  [SQ_STEPS];
    logic [W_E-1:0]    s_num [SQ_STEPS];
    logic [W_E-1:0]    s_res [SQ_STEPS];
    t_side             s_sd  [SQ_STEPS];
    logic              s_v   [SQ_STEPS];

    assign w_rdy[SQ_STEPS] = !i_stall;
    assign o_stall = !w_rdy[0];

    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_step
        localparam int K = SQ_STEPS - 1 - j;
        logic [W_E-1:0] w_bit, w_try, n_num, n_res;
        logic           w_ge;

        if (j == 0) begin : g_first
            assign s_num[j] = i_eq.e;
            assign s_res[j] = '0;
            assign s_v[j]   = i_valid;
            assign s_sd[j]  = '{nohit: i_eq.nohit, near: i_eq.near, a: i_eq.a, b: i_eq.b};
        end else begin : g_next
            assign s_num[j] = r_num[j-1];
            assign s_res[j] = r_res[j-1];
            assign s_v[j]   = r_v[j-1];
            assign s_sd[j]  = r_sd[j-1];
        end

        assign w_bit = {{(W_E-1){1'b0}}, 1'b1} << (2 * K);
        assign w_try = s_res[j] + w_bit;
        assign w_ge  = (s_num[j] >= w_try);
        assign n_num = w_ge ? (s_num[j] - w_try) : s_num[j];
        assign n_res = w_ge ? ((s_res[j] >> 1) + w_bit) : (s_res[j] >> 1);
        assign w_rdy[j] = !r_v[j] || w_rdy[j+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (w_rdy[j]) begin
                r_v[j] <= s_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[j]) begin
                r_num[j] <= n_num;
                r_res[j] <= n_res;
                r_sd[j]  <= s_sd[j];
            end
        end
    end

    assign o_valid  = r_v[SQ_STEPS-1];
    assign o_sq.nohit = r_sd[SQ_STEPS-1].nohit;
    assign o_sq.near  = r_sd[SQ_STEPS-1].near;
    assign o_sq.a     = r_sd[SQ_STEPS-1].a;
    assign o_sq.b     = r_sd[SQ_STEPS-1].b;
    assign o_sq.s     = r_res[SQ_STEPS-1][W_S-1:0];

endmodule

`default_nettype wire

### hw/rtl/rsi_div.sv
// root numerator, saturation check, restoring divide, result format
`default_nettype none

module rsi_div import rsi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_sq  i_sq,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_item
);

    typedef struct packed {
        logic                 nohit;
        logic                 sat;
        logic [W_A-1:0]       a;
        logic [DIV_STEPS-1:0] q;
    } t_dside;

    logic w_rdy1, w_rdy2, w_rdy_out;
    logic r1_v, r2_v, r_ov;

    // stage 1: n = -b -/+ s, scaled by the fraction bits
    logic [W_N:0]     w_bext, w_sext, w_n;
    logic             r1_nohit;
    logic [W_A-1:0]   r1_a;
    logic [W_REM-1:0] r1_num;

    always_comb begin
        w_bext = {{(W_N + 1 - W_B){i_sq.b[W_B-1]}}, i_sq.b};
        w_sext = {{(W_N + 1 - W_S){1'b0}}, i_sq.s};
        w_n    = i_sq.near ? ('0 - w_bext - w_sext) : ('0 - w_bext + w_sext);
    end

    // stage 2: quotient of 2^32 or more saturates
    logic             r2_nohit, r2_sat;
    logic [W_A-1:0]   r2_a;
    logic [W_REM-1:0] r2_num;

    // divide steps
    logic [DIV_STEPS:0] w_rdy;
    logic               r_v   [DIV_STEPS];
    logic [W_REM-1:0]   r_rem [DIV_STEPS];
    t_dside             r_sd  [DIV_STEPS];
    logic               s_v   [DIV_STEPS];
    logic [W_REM-1:0]   s_rem [DIV_STEPS];
    t_dside             s_sd  [DIV_STEPS];

    t_out r_out;

    assign w_rdy_out = !r_ov || !i_stall;
    assign w_rdy[DIV_STEPS] = w_rdy_out;
    assign w_rdy2    = !r2_v || w_rdy[0];
    assign w_rdy1    = !r1_v || w_rdy2;
    assign o_stall   = !w_rdy1;

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
        localparam int I = DIV_STEPS - 1 - j;
        logic [W_REM-1:0] w_den;
        logic             w_ge;
        t_dside           n_sd;

        if (j == 0) begin : g_first
            assign s_v[j]   = r2_v;
            assign s_rem[j] = r2_num;
            assign s_sd[j]  = '{nohit: r2_nohit, sat: r2_sat, a: r2_a, q: '0};
        end else begin : g_next
            assign s_v[j]   = r_v[j-1];
            assign s_rem[j] = r_rem[j-1];
            assign s_sd[j]  = r_sd[j-1];
        end

        assign w_den = {{DIV_STEPS{1'b0}}, s_sd[j].a} << I;
        assign w_ge  = (s_rem[j] >= w_den);
        always_comb begin
            n_sd = s_sd[j];
            n_sd.q[I] = w_ge;
        end
        assign w_rdy[j] = !r_v[j] || w_rdy[j+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (w_rdy[j]) begin
                r_v[j] <= s_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[j]) begin
                r_rem[j] <= w_ge ? (s_rem[j] - w_den) : s_rem[j];
                r_sd[j]  <= n_sd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_rdy1)    r1_v <= i_valid;
            if (w_rdy2)    r2_v <= r1_v;
            if (w_rdy_out) r_ov <= r_v[DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r1_nohit <= i_sq.nohit;
            r1_a     <= i_sq.a;
            r1_num   <= {{(W_REM - W_N - FRAC_BITS){1'b0}}, w_n[W_N-1:0],
                         {FRAC_BITS{1'b0}}};
        end
        if (w_rdy2) begin
            r2_nohit <= r1_nohit;
            r2_a     <= r1_a;
            r2_num   <= r1_num;
            r2_sat   <= (r1_num >= {r1_a, {DIV_STEPS{1'b0}}});
        end
        if (w_rdy_out) begin
            r_out.hit <= !r_sd[DIV_STEPS-1].nohit;
            if (r_sd[DIV_STEPS-1].nohit) begin
                r_out.hit_distance <= '0;
            end else if (r_sd[DIV_STEPS-1].sat) begin
                r_out.hit_distance <= '1;
            end else begin
                r_out.hit_distance <= r_sd[DIV_STEPS-1].q;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_item  = r_out;

endmodule

`default_nettype wire

### hw/rtl/ray_sphere_intersect.sv
// ray/sphere intersection: top level of the pipeline
//
// Tests one ray against one sphere per beat and returns one result beat per
// input beat, in order. Coordinates are signed Q16.16, the radius unsigned
// Q15.16. The ray is marked as a miss when on some axis it heads away from the
// sphere's bounding slab; otherwise the quadratic |O + tV - C|^2 = R^2 is
// solved with a truncated square root and the nearer non-negative root is
// returned (the farther one when the nearer is negative). A zero direction,
// a negative discriminant or two negative roots give hit = 0 with distance 0;
// a distance of 2^16 or more saturates to all ones. Throughput is one beat
// per clock while the result channel is not stalled. A beat passes the slab
// test and dot products, the discriminant (split 32- and 33-bit partial
// products), the square root (one result bit per stage) and the numerator,
// saturation check, 32 divide steps and the output register. Stalls push
// back stage by stage, so bubbles in the pipe are squeezed out and new beats
// keep entering while a finished result waits, until the pipe is full.
`default_nettype none

module ray_sphere_intersect import rsi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    // input channel
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_item,
    // result channel
    output logic o_valid,
    input  logic i_stall,
    output t_out o_item
);

    // handshake between the four sections
    logic w_abc_valid, w_abc_stall;
    logic w_eq_valid,  w_eq_stall;
    logic w_sq_valid,  w_sq_stall;
    t_abc w_abc;
    t_eq  w_eq;
    t_sq  w_sq;

    // slab test, origin minus center, a = V.V, b = V.D, c = D.D - R*R
    rsi_setup u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (w_abc_valid),
        .i_stall (w_abc_stall),
        .o_abc   (w_abc)
    );

    // discriminant b*b - a*c, root choice, zero direction check
    rsi_quad u_quad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_abc_valid),
        .o_stall (w_abc_stall),
        .i_abc   (w_abc),
        .o_valid (w_eq_valid),
        .i_stall (w_eq_stall),
        .o_eq    (w_eq)
    );

    // truncated square root of the discriminant
    rsi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_eq_valid),
        .o_stall (w_eq_stall),
        .i_eq    (w_eq),
        .o_valid (w_sq_valid),
        .i_stall (w_sq_stall),
        .o_sq    (w_sq)
    );

    // (-b -/+ s) / a in Q16.16, saturated, and the output register
    rsi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sq_valid),
        .o_stall (w_sq_stall),
        .i_sq    (w_sq),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

endmodule

`default_nettype wire

### hw/rtl/rsi_checker.sv
// port-level assertions for the ray/sphere block and their bind
`default_nettype none
`include "ray_sphere_intersect_macros.svh"

module rsi_checker import rsi_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic i_in_stall,
    input wire t_in  i_item,
    input wire logic i_out_valid,
    input wire logic i_stall,
    input wire t_out i_out_item
);

    // a miss always carries a zero distance
    `RSI_ASSERT_SAME(a_miss_zero, i_out_valid && !i_out_item.hit,
        i_out_item.hit_distance == '0, "miss beat with nonzero distance")

    // input back-pressure only when the full pipe is blocked at the output
    `RSI_ASSERT_SAME(a_stall_cause, i_in_stall, i_out_valid && i_stall,
        "input stalled while output is free")

    // a stalled result beat stays put
    `RSI_ASSERT_NEXT(a_out_hold, i_out_valid && i_stall,
        i_out_valid && $stable(i_out_item), "stalled result beat changed")

    // a stalled input beat stays put
    `RSI_ASSERT_NEXT(a_in_hold, i_valid && i_in_stall,
        i_valid && $stable(i_item), "stalled input beat changed")

endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .i_in_stall  (o_stall),
    .i_item      (i_item),
    .i_out_valid (o_valid),
    .i_stall     (i_stall),
    .i_out_item  (o_item)
);

`default_nettype wire
